// File: rtl/fta_pkg.sv
// ----------------------------------------------------------------------------
// fta_pkg
// shared constants and helpers for the truncating single-precision adder
// ----------------------------------------------------------------------------
package fta_pkg;

	localparam int WORD_W = 32;
	localparam int FRAC_W = 23;
	localparam int EXP_W  = 8;
	localparam int SIG_W  = FRAC_W + 1;
	localparam int MAG_W  = SIG_W + 1;
	localparam int LZC_W  = 5;
	// signed exponent wide enough for -23 .. 256
	localparam int XEXP_W = EXP_W + 2;

	// count of leading zeros from the hidden bit position down (mag is nonzero)
	function automatic logic [LZC_W-1:0] lead_zeros(input logic [SIG_W-1:0] v);
		logic [LZC_W-1:0] n;
		logic             found;
		n = '0;
		found = 1'b0;
		for (int i = SIG_W - 1; i >= 0; i--) begin
			if (!found && v[i]) begin
				n = LZC_W'(SIG_W - 1 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

endpackage

// File: rtl/fta_norm.sv
// ----------------------------------------------------------------------------
// fta_norm
// renormalize the magnitude and pack the result word
// ----------------------------------------------------------------------------
module fta_norm (
	input  logic                              sign,
	input  logic [fta_pkg::EXP_W-1:0]         exp_in,
	input  logic [fta_pkg::MAG_W-1:0]         mag,
	output logic [fta_pkg::WORD_W-1:0]        word,
	output logic                              range_err
);

	logic [fta_pkg::LZC_W-1:0]      lz;
	logic [fta_pkg::SIG_W-1:0]      sig;
	logic signed [fta_pkg::XEXP_W-1:0] xe;

	always_comb begin
		lz = fta_pkg::lead_zeros(mag[fta_pkg::SIG_W-1:0]);
		if (mag[fta_pkg::MAG_W-1]) begin
			sig = mag[fta_pkg::MAG_W-1:1];
			xe  = $signed({2'b00, exp_in}) + fta_pkg::XEXP_W'(1);
		end else begin
			sig = mag[fta_pkg::SIG_W-1:0] << lz;
			xe  = $signed({2'b00, exp_in}) - $signed({{(fta_pkg::XEXP_W-fta_pkg::LZC_W){1'b0}}, lz});
		end
		if (mag == '0) begin
			word      = '0;
			range_err = 1'b0;
		end else begin
			word      = {sign, xe[fta_pkg::EXP_W-1:0], sig[fta_pkg::FRAC_W-1:0]};
			range_err = xe[fta_pkg::XEXP_W-1] | xe[fta_pkg::EXP_W];
		end
	end

endmodule

// File: rtl/float32_truncating_adder.sv
// ----------------------------------------------------------------------------
// float32_truncating_adder
// single-precision add with truncation, four register stages
// ----------------------------------------------------------------------------
// channel | signals                                        | direction
// in      | in_valid in_ready addend_a addend_b            | into block
// out     | out_valid out_ready total exponent_range_error | out of block
//
// one word enters per cycle while in_ready is high; register stages are
// compare, align, add and normalize into the output register. the valid
// bit passes v_s1, v_s2 and v_s3 into out_valid. stages advance together
// whenever the output register is free or being emptied; a stall freezes
// every stage. reset clears the valid bits only.
module float32_truncating_adder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [fta_pkg::WORD_W-1:0]    addend_a,
	input  logic [fta_pkg::WORD_W-1:0]    addend_b,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [fta_pkg::WORD_W-1:0]    total,
	output logic                          exponent_range_error
);

	localparam int SW = fta_pkg::SIG_W;
	localparam int EW = fta_pkg::EXP_W;

	logic adv;
	logic v_s1, v_s2, v_s3;

	// stage 1: unpack, zero bypass, exponent compare
	logic            byp_s1;
	logic [31:0]     byp_w_s1;
	logic            sa_s1, sb_s1, swap_s1;
	logic [EW-1:0]   exp_s1, dist_s1;
	logic [SW-1:0]   ma_s1, mb_s1;
	// stage 2: aligned significands
	logic            byp_s2;
	logic [31:0]     byp_w_s2;
	logic            sa_s2, sb_s2;
	logic [EW-1:0]   exp_s2;
	logic [SW-1:0]   big_s2, sml_s2;
	// stage 3: magnitude
	logic            byp_s3;
	logic [31:0]     byp_w_s3;
	logic            sign_s3;
	logic [EW-1:0]   exp_s3;
	logic [fta_pkg::MAG_W-1:0] mag_s3;

	logic [31:0] norm_w;
	logic        norm_err;

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	logic [EW-1:0] ea, eb;
	assign ea = addend_a[30:23];
	assign eb = addend_b[30:23];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; out_valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byp_s1   <= (addend_a == '0) || (addend_b == '0);
			byp_w_s1 <= (addend_a == '0) ? addend_b : addend_a;
			sa_s1    <= addend_a[31];
			sb_s1    <= addend_b[31];
			ma_s1    <= {1'b1, addend_a[22:0]};
			mb_s1    <= {1'b1, addend_b[22:0]};
			swap_s1  <= !(ea > eb);
			exp_s1   <= (ea > eb) ? ea : eb;
			dist_s1  <= (ea > eb) ? ea - eb : eb - ea;

			byp_s2   <= byp_s1;
			byp_w_s2 <= byp_w_s1;
			sa_s2    <= sa_s1;
			sb_s2    <= sb_s1;
			exp_s2   <= exp_s1;
			// keep operand order: big_s2 holds a, sml_s2 holds b after alignment
			big_s2   <= swap_s1 ? ((dist_s1 >= 8'd24) ? '0 : ma_s1 >> dist_s1) : ma_s1;
			sml_s2   <= swap_s1 ? mb_s1 : ((dist_s1 >= 8'd24) ? '0 : mb_s1 >> dist_s1);

			byp_s3   <= byp_s2;
			byp_w_s3 <= byp_w_s2;
			exp_s3   <= exp_s2;
			if (sa_s2 == sb_s2) begin
				mag_s3  <= {1'b0, big_s2} + {1'b0, sml_s2};
				sign_s3 <= sa_s2;
			end else if (big_s2 >= sml_s2) begin
				mag_s3  <= {1'b0, big_s2 - sml_s2};
				sign_s3 <= sa_s2;
			end else begin
				mag_s3  <= {1'b0, sml_s2 - big_s2};
				sign_s3 <= sb_s2;
			end

			total                <= byp_s3 ? byp_w_s3 : norm_w;
			exponent_range_error <= byp_s3 ? 1'b0 : norm_err;
		end
	end

	fta_norm u_norm (
		.sign      (sign_s3),
		.exp_in    (exp_s3),
		.mag       (mag_s3),
		.word      (norm_w),
		.range_err (norm_err)
	);

endmodule

// File: rtl/fta_checker.sv
// ----------------------------------------------------------------------------
// fta_checker
// port-level checks for the truncating adder
// ----------------------------------------------------------------------------
module fta_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] total,
	input logic        exponent_range_error
);

	// a held result word stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(total) && $stable(exponent_range_error))
		else $error("result changed while stalled");

	// ready only drops when the output is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output stall");

	// a waiting result word is not withdrawn
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped before accept");

	// a word accepted with a free pipe shows up at out_valid
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready ##1 out_ready
		|=> out_valid)
		else $error("word lost in pipeline");

endmodule

bind float32_truncating_adder fta_checker u_fta_checker (.*);
